// ===== hdl/bnms_pkg.sv =====
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and register map for the block non-maximum suppression unit.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int STRENGTH_BITS = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLS    = 2'd1;
  localparam logic [1:0] REG_DIST    = 2'd2;
  localparam logic [1:0] REG_QUALITY = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [15:0] strength;
  } bnms_in_t;

  typedef struct packed {
    logic        marked;
    logic [15:0] threshold_used;
    logic        out_of_range;
  } bnms_out_t;

endpackage

// ===== hdl/block_non_maxima_suppression.sv =====
// ----------------------------------------------------------------------------
// block_non_maxima_suppression
// Block non-maximum suppression over a strength image held in on-chip memory.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | bnms_in_t
// out_    | output    | out_valid / out_ready  | bnms_out_t
// cfg_    | input     | APB psel/penable       | 32-bit register data
//
// Load, query and unused opcode: read on accept, form the result, hand it over;
// one transaction at a time.
// A run: max pass, threshold pass, mark clear over the larger of this and the
// previous run's area, then per block a block scan and, given a candidate, a
// window scan.
// Reset clears mark memory by a sweep over all MAX_ROWS*MAX_COLS entries with
// in_ready low. A stalled output holds the sequencer in its result state.
// ----------------------------------------------------------------------------
module block_non_maxima_suppression
  import bnms_pkg::*;
#(
  parameter int MAX_ROWS      = 512,
  parameter int MAX_COLS      = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bnms_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bnms_out_t        out_data,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int AB = RB + CB;
  localparam int SB = STRENGTH_BITS;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  // floor(x/100) as (x * RECIP_100) >> DIV_SHIFT, exact for x below 2^(SB+7)
  localparam int DIV_SHIFT = SB + 14;
  localparam int PW = 2 * SB + 15;
  localparam longint unsigned RECIP_100 = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_OUT   = 4'd2;
  localparam logic [3:0] S_MAX   = 4'd3;
  localparam logic [3:0] S_THR   = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_BLK   = 4'd6;
  localparam logic [3:0] S_WIN   = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;

  // configuration
  logic [9:0] rows_cfg_r, cols_cfg_r;
  logic [5:0] dist_r;
  logic [6:0] qual_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 10'd512;
      cols_cfg_r <= 10'd512;
      dist_r     <= 6'd10;
      qual_r     <= 7'd50;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ROWS:    rows_cfg_r <= cfg_pwdata[9:0];
        REG_COLS:    cols_cfg_r <= cfg_pwdata[9:0];
        REG_DIST:    dist_r     <= cfg_pwdata[5:0];
        REG_QUALITY: qual_r     <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ROWS:    cfg_prdata = {22'd0, rows_cfg_r};
      REG_COLS:    cfg_prdata = {22'd0, cols_cfg_r};
      REG_DIST:    cfg_prdata = {26'd0, dist_r};
      REG_QUALITY: cfg_prdata = {25'd0, qual_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // effective sizes, 14 bits covers up to 8192 plus headroom
  logic [13:0] rows_e, cols_e, d_e, bs_e;
  logic [6:0]  q_e;
  always_comb begin
    rows_e = (rows_cfg_r == 10'd0) ? 14'd1 :
             ({4'd0, rows_cfg_r} > 14'(MAX_ROWS)) ? 14'(MAX_ROWS) : {4'd0, rows_cfg_r};
    cols_e = (cols_cfg_r == 10'd0) ? 14'd1 :
             ({4'd0, cols_cfg_r} > 14'(MAX_COLS)) ? 14'(MAX_COLS) : {4'd0, cols_cfg_r};
    d_e    = {8'd0, dist_r};
    bs_e   = d_e + 14'd1;
    q_e    = (qual_r > 7'd100) ? 7'd100 : qual_r;
  end

  // memories
  logic [SB-1:0] smem [DEPTH];
  logic          mmem [DEPTH];
  logic [AB-1:0] raddr, waddr;
  logic          swe, mwe, mwd;
  logic [SB-1:0] swd, srd_r;
  logic          mrd_r;

  always_ff @(posedge clk) begin
    if (swe) smem[waddr] <= swd;
    srd_r <= smem[raddr];
  end
  always_ff @(posedge clk) begin
    if (mwe) mmem[waddr] <= mwd;
    mrd_r <= mmem[raddr];
  end

  // sequencer state
  logic [3:0]  st_r, st_nxt;
  bnms_in_t    cmd_r;
  logic        oor_r;
  logic [15:0] thr_r;
  logic [SB-1:0] maxv_r, thrv_r, best_r, nmax_r;
  logic [13:0] r_r, c_r;           // scan position
  logic [13:0] bm_r, bn_r;         // block origin
  logic [13:0] br_r, bc_r;         // candidate
  logic        found_r;
  logic        pv_r;               // read issued last cycle
  logic [13:0] pr_r, pc_r;         // position of that read
  logic        last_r;             // that read was the final of a pass
  logic [13:0] mark_rows_r, mark_cols_r;  // area that may still hold marks
  logic [SB+6:0] prod_r;
  logic [AB:0] clr_r;
  logic        ov_r;
  bnms_out_t   od_r;

  logic        acc;
  assign acc = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data = od_r;

  function automatic logic elig(input logic [13:0] r, input logic [13:0] c,
                                input logic [13:0] nr, input logic [13:0] nc,
                                input logic [13:0] d);
    return (r >= d) && (r + d < nr) && (c >= d) && (c + d < nc);
  endfunction

  // block extents and window bounds
  logic [13:0] ber, bec, r0, r1, c0, c1, zr_e, zc_e;
  always_comb begin
    ber = (bm_r + bs_e < rows_e) ? bm_r + bs_e : rows_e;
    bec = (bn_r + bs_e < cols_e) ? bn_r + bs_e : cols_e;
    r0  = (br_r >= d_e) ? br_r - d_e : 14'd0;
    r1  = (br_r + d_e + 14'd1 < rows_e) ? br_r + d_e + 14'd1 : rows_e;
    c0  = (bc_r >= d_e) ? bc_r - d_e : 14'd0;
    c1  = (bc_r + d_e + 14'd1 < cols_e) ? bc_r + d_e + 14'd1 : cols_e;
    zr_e = (mark_rows_r > rows_e) ? mark_rows_r : rows_e;
    zc_e = (mark_cols_r > cols_e) ? mark_cols_r : cols_e;
  end

  function automatic logic [AB-1:0] addr(input logic [13:0] r, input logic [13:0] c);
    return {r[RB-1:0], c[CB-1:0]};
  endfunction

  // scan stepping: next position and wrap flags within a rectangle
  logic [13:0] sr_hi, sc_lo, sc_hi;
  logic        sc_wrap, s_end;
  always_comb begin
    case (st_r)
      S_BLK:   begin sr_hi = ber;    sc_lo = bn_r;  sc_hi = bec;    end
      S_WIN:   begin sr_hi = r1;     sc_lo = c0;    sc_hi = c1;     end
      S_ZERO:  begin sr_hi = zr_e;   sc_lo = 14'd0; sc_hi = zc_e;   end
      default: begin sr_hi = rows_e; sc_lo = 14'd0; sc_hi = cols_e; end
    endcase
    sc_wrap = (c_r + 14'd1 >= sc_hi);
    s_end   = sc_wrap && (r_r + 14'd1 >= sr_hi);
  end

  logic rd_in, rd_elig, blk_hit;
  logic [PW-1:0] quo_full;
  logic [SB-1:0] quo_w;
  always_comb begin
    rd_in    = (pr_r >= bm_r) && (pr_r < ber) && (pc_r >= bn_r) && (pc_r < bec);
    rd_elig  = elig(pr_r, pc_r, rows_e, cols_e, d_e);
    blk_hit  = pv_r && rd_elig && (!found_r || srd_r > best_r);
    quo_full = PW'(prod_r) * PW'(RECIP_100);
    quo_w    = SB'(quo_full >> DIV_SHIFT);
  end

  logic scan_st;
  assign scan_st = (st_r == S_MAX) || (st_r == S_THR) || (st_r == S_ZERO) ||
                   (st_r == S_BLK) || (st_r == S_WIN);

  always_comb begin
    raddr = addr(r_r, c_r);
    waddr = addr(pr_r, pc_r);
    swe = 1'b0; swd = '0; mwe = 1'b0; mwd = 1'b0;
    if (st_r == S_CLR) begin
      mwe = 1'b1; waddr = clr_r[AB-1:0];
    end else if (st_r == S_IDLE) begin
      raddr = addr({5'd0, in_data.row}, {5'd0, in_data.col});
    end else if (st_r == S_ACC) begin
      waddr = addr({5'd0, cmd_r.row}, {5'd0, cmd_r.col});
      if (cmd_r.opcode == OP_LOAD && !oor_r) begin
        swe = 1'b1; swd = SB'(cmd_r.strength);
      end
    end else if (st_r == S_THR && pv_r) begin
      swe = (srd_r <= thrv_r); swd = '0;
    end else if (st_r == S_ZERO) begin
      waddr = addr(r_r, c_r); mwe = 1'b1;
    end else if (st_r == S_DEC) begin
      waddr = addr(br_r, bc_r);
      mwe = found_r && (best_r != '0) && (best_r > nmax_r); mwd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      ov_r   <= 1'b0;
      thr_r  <= 16'd0;
      pv_r   <= 1'b0;
      last_r <= 1'b0;
      mark_rows_r <= 14'd1;
      mark_cols_r <= 14'd1;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AB+1)'(DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            cmd_r <= in_data;
            oor_r <= ({5'd0, in_data.row} >= rows_e) || ({5'd0, in_data.col} >= cols_e);
            if (in_data.opcode == OP_RUN) begin
              st_r <= S_MAX; r_r <= '0; c_r <= '0; maxv_r <= '0; pv_r <= 1'b0;
            end else begin
              st_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          od_r.marked <= (cmd_r.opcode == OP_QUERY) && !oor_r && mrd_r;
          od_r.out_of_range <= (cmd_r.opcode == OP_LOAD || cmd_r.opcode == OP_QUERY) && oor_r;
          od_r.threshold_used <= thr_r;
          ov_r <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_ready) st_r <= S_IDLE;
        end
        S_MUL: begin
          prod_r <= (SB+7)'(maxv_r) * (SB+7)'(q_e);
          st_r <= S_DIV;
        end
        S_DIV: begin
          thrv_r <= quo_w;
          thr_r  <= 16'(quo_w);
          st_r <= S_THR; r_r <= '0; c_r <= '0; pv_r <= 1'b0;
        end
        S_DEC: begin
          if (bn_r + bs_e < cols_e) begin
            bn_r <= bn_r + bs_e;
            r_r <= bm_r; c_r <= bn_r + bs_e;
            st_r <= S_BLK; found_r <= 1'b0; best_r <= '0; pv_r <= 1'b0;
          end else if (bm_r + bs_e < rows_e) begin
            bm_r <= bm_r + bs_e; bn_r <= '0;
            r_r <= bm_r + bs_e; c_r <= '0;
            st_r <= S_BLK; found_r <= 1'b0; best_r <= '0; pv_r <= 1'b0;
          end else begin
            od_r <= '{marked: 1'b0, threshold_used: thr_r, out_of_range: 1'b0};
            ov_r <= 1'b1;
            st_r <= S_OUT;
          end
        end
        default: begin
          if (scan_st) begin
            // consume read from last cycle
            if (pv_r) begin
              case (st_r)
                S_MAX: if (srd_r > maxv_r) maxv_r <= srd_r;
                S_BLK: if (rd_elig && (!found_r || srd_r > best_r)) begin
                  best_r <= srd_r; br_r <= pr_r; bc_r <= pc_r; found_r <= 1'b1;
                end
                S_WIN: if (!rd_in && rd_elig && srd_r > nmax_r) nmax_r <= srd_r;
                default: ;
              endcase
            end
            if (last_r) begin
              pv_r <= 1'b0; last_r <= 1'b0;
              case (st_r)
                S_MAX: st_r <= S_MUL;
                S_THR: begin st_r <= S_ZERO; r_r <= '0; c_r <= '0; end
                S_BLK: begin
                  // skip the window when the block holds no eligible pixel
                  if (found_r || blk_hit) begin
                    st_r <= S_WIN; nmax_r <= '0;
                    r_r <= blk_hit ? ((pr_r >= d_e) ? pr_r - d_e : 14'd0) : r0;
                    c_r <= blk_hit ? ((pc_r >= d_e) ? pc_r - d_e : 14'd0) : c0;
                  end else begin
                    st_r <= S_DEC;
                  end
                end
                default: st_r <= S_DEC;
              endcase
            end else begin
              pv_r <= (st_r != S_ZERO); pr_r <= r_r; pc_r <= c_r;
              last_r <= s_end && (st_r != S_ZERO);
              if (s_end && st_r == S_ZERO) begin
                st_r <= S_BLK; bm_r <= '0; bn_r <= '0; r_r <= '0; c_r <= '0;
                found_r <= 1'b0; best_r <= '0;
                mark_rows_r <= rows_e; mark_cols_r <= cols_e;
              end else if (sc_wrap) begin
                c_r <= sc_lo; r_r <= r_r + 14'd1;
              end else begin
                c_r <= c_r + 14'd1;
              end
            end
          end else begin
            st_r <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready || !$past(out_valid))
    else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready)
    else $error("accept while busy");
`endif

endmodule
